// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is asserted.
`define PNT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property, active in reset as well.
`define PNT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pnt_pkg.sv =====
package pnt_pkg;

  // Width of the tested number.
  localparam int VALUE_WIDTH = 16;
  // Width of the reported divisor sum (saturating).
  localparam int SUM_WIDTH   = 18;
  // Internal accumulator: wide enough for the full aliquot sum.
  localparam int ACC_WIDTH   = (2 * VALUE_WIDTH > SUM_WIDTH) ? 2 * VALUE_WIDTH : SUM_WIDTH + 1;
  // Step counter of the remainder unit.
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

  // Status from the remainder unit.
  typedef struct packed {
    logic done;      // one-cycle pulse, remainder ready
    logic rem_zero;  // remainder is zero (valid with done)
  } rem_status_t;

  // One finished result.
  typedef struct packed {
    logic [SUM_WIDTH-1:0] divisor_sum;
    logic                 is_perfect;
  } result_t;

endpackage

// ===== hw/rtl/perfect_number_test.sv =====
// Aliquot-sum / perfect-number test, one number at a time.
// Each trial divisor d = 1..value/2 goes through a start state, VALUE_WIDTH remainder steps
// and a done pulse; the result is then offered to the output register.
// A new number is taken only when the sequencer is idle (in_ready only in idle).
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid.
`include "assert_macros.svh"

module perfect_number_test (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pnt_pkg::VALUE_WIDTH-1:0]  in_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pnt_pkg::SUM_WIDTH-1:0]    out_divisor_sum,
  output logic                             out_is_perfect
);
  import pnt_pkg::*;

  logic                   rem_start;
  logic [VALUE_WIDTH-1:0] rem_dividend;
  logic [VALUE_WIDTH-1:0] rem_divisor;
  rem_status_t            rem_st;
  logic                   res_valid;
  logic                   res_ready;
  result_t                res;
  logic                   out_valid_r;
  result_t                out_r;

  pnt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .rem_start    (rem_start),
    .rem_dividend (rem_dividend),
    .rem_divisor  (rem_divisor),
    .rem_st       (rem_st),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res)
  );

  pnt_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (rem_divisor),
    .status   (rem_st)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_divisor_sum = out_r.divisor_sum;
  assign out_is_perfect  = out_r.is_perfect;

  // Checks
  `PNT_ASSERT(a_idle_no_result, clk, rst_n, in_ready |-> !res_valid, "result pending while idle")
  `PNT_ASSERT(a_result_loaded, clk, rst_n, (res_valid && res_ready) |=> out_valid, "result not loaded")
  `PNT_ASSERT(a_busy_in_div, clk, rst_n, rem_start |=> !in_ready, "input taken during division")
  `PNT_ASSERT(a_done_pulse, clk, rst_n, rem_st.done |=> !rem_st.done, "remainder done held")

endmodule

// ===== hw/rtl/pnt_rem.sv =====
module pnt_rem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [pnt_pkg::VALUE_WIDTH-1:0]  dividend,
  input  logic [pnt_pkg::VALUE_WIDTH-1:0]  divisor,
  output pnt_pkg::rem_status_t             status
);
  import pnt_pkg::*;

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_WIDTH-1:0]   cnt_r, cnt_nxt;
  logic [VALUE_WIDTH-1:0] rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] sh_r, sh_nxt;
  logic [VALUE_WIDTH-1:0] trial;

  // Restoring remainder, one dividend bit per cycle, MSB first.
  // The divisor never exceeds half the range, so the partial remainder
  // fits in VALUE_WIDTH-1 bits and the trial value in VALUE_WIDTH bits.
  assign trial = {rem_r[VALUE_WIDTH-2:0], sh_r[VALUE_WIDTH-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_WIDTH'(VALUE_WIDTH);
      rem_nxt  = '0;
      sh_nxt   = dividend;
    end else if (busy_r) begin
      rem_nxt = (trial >= divisor) ? (trial - divisor) : trial;
      sh_nxt  = {sh_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_WIDTH'(1);
      if (cnt_r == CNT_WIDTH'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  assign status.done     = done_r;
  assign status.rem_zero = (rem_r == '0);

endmodule

// ===== hw/rtl/pnt_ctrl.sv =====
module pnt_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [pnt_pkg::VALUE_WIDTH-1:0]  in_value,
  output logic                             rem_start,
  output logic [pnt_pkg::VALUE_WIDTH-1:0]  rem_dividend,
  output logic [pnt_pkg::VALUE_WIDTH-1:0]  rem_divisor,
  input  pnt_pkg::rem_status_t             rem_st,
  output logic                             res_valid,
  input  logic                             res_ready,
  output pnt_pkg::result_t                 res
);
  import pnt_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] n_r, n_nxt;
  logic [VALUE_WIDTH-1:0] half_r, half_nxt;
  logic [VALUE_WIDTH-1:0] d_r, d_nxt;
  logic [ACC_WIDTH-1:0]   acc_r, acc_nxt;
  logic [VALUE_WIDTH-1:0] in_half;

  assign in_half = in_value >> 1;

  // Sequencer: walk d = 1..n/2, one remainder per divisor
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    half_nxt  = half_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    in_ready  = 1'b0;
    rem_start = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          n_nxt     = in_value;
          half_nxt  = in_half;
          d_nxt     = VALUE_WIDTH'(1);
          acc_nxt   = '0;
          // zero and one have no candidate divisors
          state_nxt = (in_half == '0) ? ST_DONE : ST_START;
        end
      end
      ST_START: begin
        rem_start = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (rem_st.done) begin
          if (rem_st.rem_zero) begin
            acc_nxt = acc_r + ACC_WIDTH'(d_r);
          end
          if (d_r == half_r) begin
            state_nxt = ST_DONE;
          end else begin
            d_nxt     = d_r + VALUE_WIDTH'(1);
            state_nxt = ST_START;
          end
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    half_r <= half_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
  end

  assign rem_dividend = n_r;
  assign rem_divisor  = d_r;

  // Saturate the reported sum; the flag uses the full sum
  assign res.divisor_sum = (acc_r[ACC_WIDTH-1:SUM_WIDTH] != '0) ? '1 : acc_r[SUM_WIDTH-1:0];
  assign res.is_perfect  = (acc_r == ACC_WIDTH'(n_r));

endmodule

// ===== tb/perfect_number_test_tb.sv =====
`timescale 1ns / 100ps

module perfect_number_test_tb;
  import pnt_pkg::*;

  localparam int SUM_MAX = (1 << SUM_WIDTH) - 1;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [VALUE_WIDTH-1:0] in_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SUM_WIDTH-1:0]   out_divisor_sum;
  logic                   out_is_perfect;

  // Expected results, oldest first
  result_t pending_results[$];
  int      mismatch_count = 0;

  // Idling control; no_idle is shared by both sides
  bit      no_idle = 1'b0;
  int      hold_off_request = 0;
  int      hold_left = 0;
  int      ready_gap_left = 0;

  perfect_number_test u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_divisor_sum(out_divisor_sum),
    .out_is_perfect (out_is_perfect)
  );

  always #5 clk = ~clk;

  // Sum of proper divisors, saturated to the reported width; flag uses the full sum
  function automatic result_t predict_aliquot(input logic [VALUE_WIDTH-1:0] n);
    logic [31:0] acc;
    int unsigned d;
    result_t     res;
    acc = '0;
    for (d = 1; d <= n / 2; d++) begin
      if (n % d == 0) acc += d;
    end
    res.divisor_sum = (acc > SUM_MAX) ? SUM_MAX[SUM_WIDTH-1:0] : acc[SUM_WIDTH-1:0];
    res.is_perfect  = (acc == n);
    return res;
  endfunction

  // Mostly small numbers keep the bit-serial divider fast
  function automatic logic [VALUE_WIDTH-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return VALUE_WIDTH'($urandom_range(0, 15));
    else if (r < 85) return VALUE_WIDTH'($urandom_range(0, 255));
    else return VALUE_WIDTH'($urandom_range(256, 2047));
  endfunction

  function automatic int sender_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(10, 50);
  endfunction

  // Offer one beat and wait for it to be taken
  task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_aliquot(v));
  endtask

  // Drop valid for a pause of length n; zero keeps the stream back to back
  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_list(input logic [VALUE_WIDTH-1:0] vals[$]);
    foreach (vals[i]) begin
      send_value(vals[i]);
      pause_sender(sender_gap());
    end
  endtask

  task automatic wait_all_results();
    pause_sender(1);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, forced hold-off, or always ready
  always @(posedge clk) begin
    if (hold_off_request != 0) begin
      hold_left = hold_off_request;
      hold_off_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if (ready_gap_left > 0) begin
      ready_gap_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 20) begin
      ready_gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) - 1
                                                   : $urandom_range(1, 3) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Result checker: each accepted beat against the oldest expectation
  always @(posedge clk) begin
    result_t exp_res;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: sum=%0d perfect=%0b",
                   $time, out_divisor_sum, out_is_perfect);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_divisor_sum !== exp_res.divisor_sum ||
            out_is_perfect !== exp_res.is_perfect) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected sum=%0d perfect=%0b, actual sum=%0d perfect=%0b",
                     $time, exp_res.divisor_sum, exp_res.is_perfect,
                     out_divisor_sum, out_is_perfect);
        end
      end
    end
  end

  // Zero, one and the smallest numbers with no trial divisors or only one
  task automatic test_special_cases();
    send_list('{16'd0, 16'd1, 16'd2, 16'd3});
  endtask

  // All perfect numbers that fit in 16 bits
  task automatic test_perfect_numbers();
    send_list('{16'd6, 16'd28, 16'd496, 16'd8128});
  endtask

  // Primes, abundant and deficient numbers, byte boundary
  task automatic test_divisor_mix();
    send_list('{16'd4, 16'd12, 16'd13, 16'd97, 16'd255, 16'd256, 16'd945});
  endtask

  // Largest input: every value bit high, longest trial loop
  task automatic test_full_scale();
    send_list('{16'hFFFF});
  endtask

  // Receiver hold-off while items keep coming. It is requested while the full-scale item
  // from the test before is still in the sequencer, so it runs out before these small numbers
  // reach the output; it does not leave the output register and the sequencer both holding a result.
  task automatic test_input_stall();
    int i;
    hold_off_request = 400;
    for (i = 0; i < 6; i++) send_value(VALUE_WIDTH'($urandom_range(0, 15)));
  endtask

  // Sender waits for all results of a first batch before sending a second
  task automatic test_drain_pause();
    int i;
    for (i = 0; i < 5; i++) begin
      send_value(rand_value());
      pause_sender(sender_gap());
    end
    wait_all_results();
    for (i = 0; i < 5; i++) begin
      send_value(rand_value());
      pause_sender(sender_gap());
    end
  endtask

  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      send_value(rand_value());
      pause_sender(sender_gap());
    end
  endtask

  // Stretch with no idling on either side
  task automatic test_steady_stream(input int count);
    int i;
    no_idle = 1'b1;
    for (i = 0; i < count; i++) send_value(rand_value());
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_special_cases();
    test_perfect_numbers();
    test_divisor_mix();
    test_full_scale();
    test_input_stall();
    test_drain_pause();
    test_random_traffic(65);
    test_steady_stream(20);

    // Let everything drain, then watch for stray beats
    wait_all_results();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
